### design/assert_macros.svh
// Assertion macros used by the lexer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock, off while reset is high.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// Implication with the consequent checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/bnl_pkg.sv
// ----------------------------------------------------------------------------
// bnl_pkg
// Types and character codes for the numeric literal lexer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bnl_pkg;

   typedef enum logic [2:0] {
      MODE_IDLE     = 3'd0,
      MODE_WHOLE    = 3'd1,
      MODE_DECIMAL  = 3'd2,
      MODE_EXPSIGN  = 3'd3,
      MODE_EXPONENT = 3'd4
   } scan_mode_type;

   typedef enum logic [1:0] {
      KIND_LINE_NUMBER = 2'd0,
      KIND_NUMBER      = 2'd1,
      KIND_OTHER       = 2'd2
   } token_kind_type;

   typedef enum logic [2:0] {
      ERR_OK            = 3'd0,
      ERR_NO_FRACTION   = 3'd1,
      ERR_DIGITS_BEFORE = 3'd2,
      ERR_NO_EXPONENT   = 3'd3,
      ERR_NO_EXP_DIGITS = 3'd4
   } error_code_type;

   typedef struct packed {
      token_kind_type kind;
      error_code_type error;
      logic [11:0]    column;
      logic [7:0]     length;
      logic           last;
   } result_type;

   localparam logic [7:0] CH_POINT   = 8'h2E;
   localparam logic [7:0] CH_E_LOWER = 8'h65;
   localparam logic [7:0] CH_E_UPPER = 8'h45;
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_MINUS   = 8'h2D;
   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_CR      = 8'h0D;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;

endpackage

`default_nettype wire

### design/basic_number_lexer.sv
// ----------------------------------------------------------------------------
// basic_number_lexer
// Lexes numeric literals from a character stream and reports one record
// per token: kind, error code, start column and length.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake        | payload
//  req_     | in        | req_valid/ready  | ch, end_of_input
//  rsp_     | out       | rsp_valid/ready  | token_kind, error_code,
//           |           |                  | token_column, token_length,
//           |           |                  | last_of_run
//
//  One character per cycle while req_ready is high: scanner state updates
//  in the accept cycle and its records enter a 4-entry result queue,
//  drained one record per cycle while rsp_ready is high. A character may
//  yield two records; sustained rate is then bounded by the single-record
//  output port. req_ready is high while the queue has room for two records.
//  Reset is synchronous and clears the scanner and the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module basic_number_lexer
   import bnl_pkg::*;
#(
   parameter int MAX_COLUMN       = 4095,
   parameter int MAX_TOKEN_LENGTH = 255
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_ch,
   input  wire logic        req_end_of_input,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_token_kind,
   output logic [2:0]       rsp_error_code,
   output logic [11:0]      rsp_token_column,
   output logic [7:0]       rsp_token_length,
   output logic             rsp_last_of_run
);

   localparam int COL_W = $clog2(MAX_COLUMN + 1);
   localparam int LEN_W = $clog2(MAX_TOKEN_LENGTH + 1);
   localparam logic [COL_W-1:0] COL_MAX = COL_W'(MAX_COLUMN);
   localparam logic [COL_W-1:0] COL_ONE = COL_W'(1);
   localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_TOKEN_LENGTH);
   localparam logic [LEN_W-1:0] LEN_ONE = LEN_W'(1);

   // scanner state
   scan_mode_type    mode_ff, mode_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [COL_W-1:0] start_ff, start_in;
   logic [LEN_W-1:0] count_ff, count_in;
   logic             point_ff, point_in;
   logic             exp_ff, exp_in;
   logic             frac_dig_ff, frac_dig_in;
   logic             exp_dig_ff, exp_dig_in;

   // result queue
   result_type       queue_ff [4];
   logic [1:0]       wr_ptr_ff, wr_ptr_in;
   logic [1:0]       rd_ptr_ff, rd_ptr_in;
   logic [2:0]       fill_ff, fill_in;

   logic             accept, pop;
   logic             is_digit, is_space, is_exp_mark, is_sign;
   logic             emit_num, emit_other, taken, ended;
   error_code_type   num_err;
   logic [COL_W-1:0] col_next;
   result_type       num_res, other_res, res0, res1;
   logic [1:0]       push_count;
   logic [COL_W+11:0] start_wide, col_wide;
   logic [LEN_W+7:0]  len_wide;

   function automatic error_code_type plain_end_code(scan_mode_type m, logic frac_dig,
                                                     logic exp_dig);
      error_code_type code;
      code = ERR_OK;
      case (m)
         MODE_DECIMAL:  code = frac_dig ? ERR_OK : ERR_NO_FRACTION;
         MODE_EXPSIGN:  code = ERR_NO_EXPONENT;
         MODE_EXPONENT: code = exp_dig ? ERR_OK : ERR_NO_EXP_DIGITS;
         default:       code = ERR_OK;
      endcase
      return code;
   endfunction

   assign accept = req_valid && req_ready;
   assign pop    = rsp_valid && rsp_ready;

   assign is_digit    = req_ch inside {[CH_ZERO:CH_NINE]};
   assign is_space    = (req_ch == CH_SPACE) || (req_ch inside {[CH_TAB:CH_CR]});
   assign is_exp_mark = (req_ch == CH_E_LOWER) || (req_ch == CH_E_UPPER);
   assign is_sign     = (req_ch == CH_PLUS) || (req_ch == CH_MINUS);

   assign col_next = (req_ch == CH_NEWLINE) ? COL_ONE :
                     (col_ff < COL_MAX) ? col_ff + COL_ONE : col_ff;

   always_comb begin
      mode_in     = mode_ff;
      col_in      = col_ff;
      start_in    = start_ff;
      count_in    = count_ff;
      point_in    = point_ff;
      exp_in      = exp_ff;
      frac_dig_in = frac_dig_ff;
      exp_dig_in  = exp_dig_ff;
      emit_num    = 1'b0;
      emit_other  = 1'b0;
      taken       = 1'b0;
      ended       = 1'b0;
      num_err     = ERR_OK;

      if (req_end_of_input) begin
         if (mode_ff != MODE_IDLE) begin
            emit_num = 1'b1;
            num_err  = plain_end_code(mode_ff, frac_dig_ff, exp_dig_ff);
         end
         mode_in = MODE_IDLE;
         col_in  = COL_ONE;
      end else begin
         case (mode_ff)
            MODE_WHOLE: begin
               if (is_digit) begin
                  taken = 1'b1;
               end else if (req_ch == CH_POINT) begin
                  point_in = 1'b1;
                  mode_in  = MODE_DECIMAL;
                  taken    = 1'b1;
               end else if (is_exp_mark) begin
                  exp_in  = 1'b1;
                  mode_in = MODE_EXPSIGN;
                  taken   = 1'b1;
               end else begin
                  ended = 1'b1;
               end
            end
            MODE_DECIMAL: begin
               if (is_digit) begin
                  frac_dig_in = 1'b1;
                  taken       = 1'b1;
               end else if (is_exp_mark && frac_dig_ff) begin
                  exp_in  = 1'b1;
                  mode_in = MODE_EXPSIGN;
                  taken   = 1'b1;
               end else if (is_exp_mark) begin
                  ended   = 1'b1;
                  num_err = ERR_DIGITS_BEFORE;
               end else begin
                  ended   = 1'b1;
                  num_err = plain_end_code(mode_ff, frac_dig_ff, exp_dig_ff);
               end
            end
            MODE_EXPSIGN: begin
               if (is_sign || is_digit) begin
                  exp_dig_in = is_digit ? 1'b1 : exp_dig_ff;
                  mode_in    = MODE_EXPONENT;
                  taken      = 1'b1;
               end else begin
                  ended   = 1'b1;
                  num_err = ERR_NO_EXPONENT;
               end
            end
            MODE_EXPONENT: begin
               if (is_digit) begin
                  exp_dig_in = 1'b1;
                  taken      = 1'b1;
               end else begin
                  ended   = 1'b1;
                  num_err = plain_end_code(mode_ff, frac_dig_ff, exp_dig_ff);
               end
            end
            default: begin
            end
         endcase

         if (taken) begin
            count_in = (count_ff < LEN_MAX) ? count_ff + LEN_ONE : count_ff;
            col_in   = col_next;
         end else begin
            if (ended) begin
               emit_num = 1'b1;
               mode_in  = MODE_IDLE;
            end
            // the character that ended a number is lexed on its own
            if (is_space) begin
            end else if (is_digit) begin
               mode_in     = MODE_WHOLE;
               start_in    = col_ff;
               count_in    = LEN_ONE;
               point_in    = 1'b0;
               exp_in      = 1'b0;
               frac_dig_in = 1'b0;
               exp_dig_in  = 1'b0;
            end else begin
               mode_in    = MODE_IDLE;
               emit_other = 1'b1;
            end
            col_in = col_next;
         end
      end
   end

   // records, masked to port widths
   assign start_wide = {12'b0, start_ff};
   assign col_wide   = {12'b0, col_ff};
   assign len_wide   = {8'b0, count_ff};

   always_comb begin
      num_res.kind   = (start_ff == COL_ONE && !point_ff && !exp_ff) ?
                       KIND_LINE_NUMBER : KIND_NUMBER;
      num_res.error  = num_err;
      num_res.column = start_wide[11:0];
      num_res.length = len_wide[7:0];
      num_res.last   = 1'b0;

      other_res.kind   = KIND_OTHER;
      other_res.error  = ERR_OK;
      other_res.column = col_wide[11:0];
      other_res.length = 8'd1;
      other_res.last   = 1'b1;

      res0 = emit_num ? num_res : other_res;
      res1 = other_res;
      res0.last  = !(emit_num && emit_other);
      push_count = {1'b0, emit_num} + {1'b0, emit_other};
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (accept) begin
         wr_ptr_in = wr_ptr_ff + push_count;
         fill_in   = fill_ff + {1'b0, push_count};
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 2'd1;
         fill_in   = fill_in - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_IDLE;
         col_ff      <= COL_ONE;
         start_ff    <= COL_ONE;
         count_ff    <= '0;
         point_ff    <= 1'b0;
         exp_ff      <= 1'b0;
         frac_dig_ff <= 1'b0;
         exp_dig_ff  <= 1'b0;
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         fill_ff     <= '0;
      end else begin
         if (accept) begin
            mode_ff     <= mode_in;
            col_ff      <= col_in;
            start_ff    <= start_in;
            count_ff    <= count_in;
            point_ff    <= point_in;
            exp_ff      <= exp_in;
            frac_dig_ff <= frac_dig_in;
            exp_dig_ff  <= exp_dig_in;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && push_count != 2'd0) begin
         queue_ff[wr_ptr_ff] <= res0;
      end
      if (accept && push_count == 2'd2) begin
         queue_ff[wr_ptr_ff + 2'd1] <= res1;
      end
   end

   assign req_ready        = (fill_ff < 3'd3);
   assign rsp_valid        = (fill_ff != 3'd0);
   assign rsp_token_kind   = queue_ff[rd_ptr_ff].kind;
   assign rsp_error_code   = queue_ff[rd_ptr_ff].error;
   assign rsp_token_column = queue_ff[rd_ptr_ff].column;
   assign rsp_token_length = queue_ff[rd_ptr_ff].length;
   assign rsp_last_of_run  = queue_ff[rd_ptr_ff].last;

   `ASSERT_CLK(a_fill_bound, fill_ff <= 3'd4 && col_ff != '0, "queue overflow or column zero")
   `ASSERT_NEXT(a_eoi_resets, accept && req_end_of_input,
      col_ff == COL_ONE && mode_ff == MODE_IDLE, "end of input did not restart column")
   `ASSERT_NEXT(a_digit_opens, accept && !req_end_of_input && mode_ff == MODE_IDLE && is_digit,
      mode_ff == MODE_WHOLE && count_ff == LEN_ONE, "digit did not open a number")
   `ASSERT_CLK(a_pair_last, !(accept && push_count == 2'd2) || (!res0.last && res1.last),
      "last_of_run misplaced in record pair")

endmodule

`default_nettype wire
